// ----- src/lz4d_pkg.sv -----
// Shared types and constants of the LZ4 block decoder.
// Holds the item structs, parse phase, sequencer state and status codes.
`default_nettype none

package lz4d_pkg;

  localparam int unsigned LenW   = 24;
  localparam int unsigned MinMatch = 4;
  localparam logic [3:0]  NibMax = 4'hF;
  localparam logic [7:0]  ExtByte = 8'hFF;
  localparam logic [LenW-1:0] LenMax = 24'hFFFFFF;
  localparam logic [LenW-1:0] CapReset = 24'd65536;

  // input item
  typedef struct packed {
    logic       action;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic            has_byte;
    logic [7:0]      out_byte;
    logic [2:0]      status;
    logic            copy_pending;
    logic [LenW-1:0] produced_count;
    logic            run_end;
  } out_item_t;

  typedef enum logic {
    ACT_DATA  = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    STS_WORKING  = 3'd0,
    STS_DONE     = 3'd1,
    STS_TRUNC    = 3'd2,
    STS_CAPACITY = 3'd3,
    STS_ZERO_OFF = 3'd4,
    STS_TOO_FAR  = 3'd5,
    STS_BUSY     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LIT_EXT,
    PH_LITERALS,
    PH_OFF_LO,
    PH_OFF_HI,
    PH_MATCH_EXT,
    PH_COPY
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_WRITE
  } seq_e;

endpackage

`default_nettype wire

// ----- src/lz4d_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the decoder history.
`default_nettype none

module lz4d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/lz4_block_decoder.sv -----
// LZ4 block decoder top level: parser, copy sequencer and output register.
// Depends on lz4d_pkg and lz4d_ram (history memory).
`default_nettype none

// Takes one compressed byte per input item and returns one or more result
// items. Token, length extension, offset and literal bytes each give one
// result, or the copy results if they start a match copy. A match copy reads
// each byte from the history memory in a read state (registered read data),
// then writes it back and emits it in a write state, at most BURST_BYTES
// bytes per item; drain items (action 1) release the rest. A data item sent
// while a copy is pending is refused with status 6. Results leave through a
// single output register; while a result waits there under stall, the next
// input item is held off, and the input stays stalled until the last byte of
// a copy burst has been emitted. The history is not cleared; it is read only
// where the current block wrote it.
module lz4_block_decoder #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned BURST_BYTES   = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lz4d_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lz4d_pkg::out_item_t       out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [23:0]          cfg_data_i
);

  import lz4d_pkg::*;

  localparam int unsigned HW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;

  // state
  seq_e            sq_q, sq_d;
  phase_e          phase_q, phase_d;
  logic [3:0]      nib_q, nib_d;
  logic [LenW-1:0] lit_q, lit_d;
  logic [15:0]     off_q, off_d;
  logic [LenW-1:0] ml_q, ml_d;
  logic [LenW-1:0] total_q, total_d;
  logic [HW-1:0]   wptr_q, wptr_d;
  logic            lic_q, lic_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [LenW-1:0] cap_q;
  logic            ovalid_q, ovalid_d;
  out_item_t       out_q, out_d;

  // memory port
  logic          mem_we, mem_re;
  logic [HW-1:0] mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // combinational helpers
  logic            can_emit, accept, emit;
  logic [2:0]      sts;
  logic            restart;
  logic [LenW:0]   sum_lit, sum_ml;
  logic [LenW-1:0] sat_lit, sat_ml;
  logic [15:0]     off_full;
  logic [HW-1:0]   off_ext;
  logic            last_res;
  in_item_t        it;

  assign cfg_ready_o = 1'b1;
  assign can_emit    = !ovalid_q || !out_stall_i;
  assign in_stall_o  = !((sq_q == SQ_IDLE) && can_emit);
  assign accept      = in_valid_i && !in_stall_o;
  assign it          = in_data_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  // saturating length sums
  assign sum_lit  = {1'b0, lit_q} + {{(LenW-7){1'b0}}, it.in_byte};
  assign sat_lit  = sum_lit[LenW] ? LenMax : sum_lit[LenW-1:0];
  assign sum_ml   = {1'b0, ml_q} + {{(LenW-7){1'b0}}, it.in_byte};
  assign sat_ml   = sum_ml[LenW] ? LenMax : sum_ml[LenW-1:0];
  assign off_full = {it.in_byte, off_q[7:0]};
  assign off_ext  = HW'(off_q);

  // copy source: (write pointer - offset) modulo the history depth
  assign mem_raddr = (wptr_q >= off_ext) ? (wptr_q - off_ext)
                                         : (wptr_q + (HW'(HISTORY_DEPTH) - off_ext));

  // literal run length complete
  function automatic logic [2:0] lit_check(input logic [LenW-1:0] l,
                                            input logic [LenW-1:0] tot,
                                            input logic [LenW-1:0] cap,
                                            input logic lst);
    logic [2:0] r;
    r = STS_WORKING;
    if (({1'b0, tot} + {1'b0, l}) > {1'b0, cap}) begin
      r = STS_CAPACITY;
    end else if (lst) begin
      r = STS_TRUNC;
    end
    return r;
  endfunction

  // match length complete
  function automatic logic [2:0] match_check(input logic [15:0] o,
                                              input logic [LenW-1:0] l,
                                              input logic [LenW-1:0] tot,
                                              input logic [LenW-1:0] cap);
    logic [2:0] r;
    r = STS_WORKING;
    if ({{(LenW-16){1'b0}}, o} > tot) begin
      r = STS_TOO_FAR;
    end else if (({1'b0, tot} + {1'b0, l}) > {1'b0, cap}) begin
      r = STS_CAPACITY;
    end
    return r;
  endfunction

  // sequencer next state
  always_comb begin
    sq_d = sq_q;
    case (sq_q)
      SQ_IDLE: begin
        if (accept && (phase_d == PH_COPY) && !emit) begin
          sq_d = SQ_READ;
        end
      end
      SQ_READ:  sq_d = SQ_WRITE;
      SQ_WRITE: begin
        if (can_emit) begin
          sq_d = last_res ? SQ_IDLE : SQ_READ;
        end
      end
      default:  sq_d = SQ_IDLE;
    endcase
  end

  // parser, copy datapath and result forming
  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    lit_d     = lit_q;
    off_d     = off_q;
    ml_d      = ml_q;
    total_d   = total_q;
    wptr_d    = wptr_q;
    lic_d     = lic_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    sts       = STS_WORKING;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = it.in_byte;
    last_res  = 1'b0;
    out_d     = '0;

    case (sq_q)
      SQ_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          cnt_d = '0;
          if (it.action == ACT_DRAIN) begin
            if (phase_q == PH_COPY) begin
              emit = 1'b0;
            end
          end else begin
            case (phase_q)
              PH_COPY: sts = STS_BUSY;
              PH_TOKEN: begin
                if ((total_q == '0) && (cap_q == '0)) begin
                  sts = STS_CAPACITY;
                end else begin
                  nib_d = it.in_byte[3:0];
                  lit_d = {{(LenW-4){1'b0}}, it.in_byte[7:4]};
                  if (it.in_byte[7:4] == NibMax) begin
                    if (it.in_last) sts = STS_TRUNC;
                    else phase_d = PH_LIT_EXT;
                  end else if (it.in_byte[7:4] != 4'd0) begin
                    sts = lit_check(lit_d, total_q, cap_q, it.in_last);
                    if (sts == STS_WORKING) phase_d = PH_LITERALS;
                  end else begin
                    if (it.in_last) sts = STS_DONE;
                    else phase_d = PH_OFF_LO;
                  end
                end
              end
              PH_LIT_EXT: begin
                lit_d = sat_lit;
                if (it.in_byte == ExtByte) begin
                  if (it.in_last) sts = STS_TRUNC;
                end else begin
                  sts = lit_check(sat_lit, total_q, cap_q, it.in_last);
                  if (sts == STS_WORKING) phase_d = PH_LITERALS;
                end
              end
              PH_LITERALS: begin
                mem_we  = 1'b1;
                total_d = total_q + 1'b1;
                wptr_d  = (wptr_q == HW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
                lit_d   = lit_q - 1'b1;
                if (lit_d == '0) begin
                  phase_d = PH_OFF_LO;
                  if (it.in_last) sts = STS_DONE;
                end else if (it.in_last) begin
                  sts = STS_TRUNC;
                end
              end
              PH_OFF_LO: begin
                off_d = {8'd0, it.in_byte};
                if (it.in_last) sts = STS_TRUNC;
                else phase_d = PH_OFF_HI;
              end
              PH_OFF_HI: begin
                off_d = off_full;
                if (off_full == 16'd0) begin
                  sts = STS_ZERO_OFF;
                end else if (nib_q == NibMax) begin
                  ml_d = LenW'(NibMax) + LenW'(MinMatch);
                  if (it.in_last) sts = STS_TRUNC;
                  else phase_d = PH_MATCH_EXT;
                end else begin
                  ml_d = LenW'(nib_q) + LenW'(MinMatch);
                  sts = match_check(off_full, ml_d, total_q, cap_q);
                  if (sts == STS_WORKING) begin
                    phase_d = PH_COPY;
                    lic_d   = it.in_last;
                    emit    = 1'b0;
                  end
                end
              end
              PH_MATCH_EXT: begin
                ml_d = sat_ml;
                if (it.in_byte == ExtByte) begin
                  if (it.in_last) sts = STS_TRUNC;
                end else begin
                  sts = match_check(off_q, sat_ml, total_q, cap_q);
                  if (sts == STS_WORKING) begin
                    phase_d = PH_COPY;
                    lic_d   = it.in_last;
                    emit    = 1'b0;
                  end
                end
              end
              default: begin
                phase_d = PH_TOKEN;
                nib_d   = '0;
                lit_d   = '0;
                off_d   = '0;
                ml_d    = '0;
                total_d = '0;
                wptr_d  = '0;
                lic_d   = 1'b0;
              end
            endcase
          end
          out_d.has_byte       = mem_we;
          out_d.out_byte       = mem_we ? it.in_byte : 8'd0;
          out_d.run_end        = 1'b1;
          out_d.copy_pending   = (phase_d == PH_COPY) && (ml_d != '0);
        end
      end
      SQ_READ: begin
        mem_re = 1'b1;
      end
      SQ_WRITE: begin
        if (can_emit) begin
          emit      = 1'b1;
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          total_d   = total_q + 1'b1;
          wptr_d    = (wptr_q == HW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
          ml_d      = ml_q - 1'b1;
          cnt_d     = cnt_q + 1'b1;
          last_res  = (ml_d == '0) || (cnt_q == CW'(BURST_BYTES - 1));
          if (ml_d == '0) begin
            phase_d = PH_TOKEN;
            if (lic_q) sts = STS_DONE;
          end
          out_d.has_byte     = 1'b1;
          out_d.out_byte     = mem_rdata;
          out_d.run_end      = last_res;
          out_d.copy_pending = (ml_d != '0);
        end
      end
      default: ;
    endcase

    out_d.status         = sts;
    out_d.produced_count = total_d;

    // end of block: start over
    restart = (sts == STS_DONE) || (sts == STS_TRUNC) || (sts == STS_CAPACITY) ||
              (sts == STS_ZERO_OFF) || (sts == STS_TOO_FAR);
    if (restart) begin
      out_d.copy_pending = 1'b0;
      phase_d = PH_TOKEN;
      nib_d   = '0;
      lit_d   = '0;
      off_d   = '0;
      ml_d    = '0;
      total_d = '0;
      wptr_d  = '0;
      lic_d   = 1'b0;
    end
  end

  // output register valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  // control and length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q     <= SQ_IDLE;
      phase_q  <= PH_TOKEN;
      nib_q    <= '0;
      lit_q    <= '0;
      off_q    <= '0;
      ml_q     <= '0;
      total_q  <= '0;
      wptr_q   <= '0;
      lic_q    <= 1'b0;
      cnt_q    <= '0;
      cap_q    <= CapReset;
      ovalid_q <= 1'b0;
    end else begin
      sq_q     <= sq_d;
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      lit_q    <= lit_d;
      off_q    <= off_d;
      ml_q     <= ml_d;
      total_q  <= total_d;
      wptr_q   <= wptr_d;
      lic_q    <= lic_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // history memory
  lz4d_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(wptr_q),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

`ifndef ASSERT_OFF
  // a pending copy always has bytes left
  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_COPY |-> ml_q != '0)
    else $error("copy phase with zero match length");

  // the copy sequencer only runs inside a copy
  a_seq_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_q != SQ_IDLE |-> phase_q == PH_COPY)
    else $error("copy sequencer busy outside copy phase");

  // only the final result of an item carries a status
  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_end) |-> out_data_o.status == STS_WORKING)
    else $error("status on a non-final result");

  // a block end never reports a pending copy
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == STS_DONE || out_data_o.status == STS_TRUNC ||
     out_data_o.status == STS_CAPACITY || out_data_o.status == STS_ZERO_OFF ||
     out_data_o.status == STS_TOO_FAR)) |-> !out_data_o.copy_pending)
    else $error("copy pending at block end");
`endif

endmodule

`default_nettype wire

// ----- dv/lz4_block_decoder_tb.sv -----
// Self-checking testbench for lz4_block_decoder: directed and random LZ4 blocks.
// Depends on lz4d_pkg for the item structs, action and status codes.
`default_nettype none

module lz4_block_decoder_tb;
  import lz4d_pkg::*;

  localparam int unsigned HistDepth = 65536;
  localparam int unsigned Burst     = 64;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [23:0] cfg_data_i = '0;

  lz4_block_decoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  out_item_t burst_results[$];
  int unsigned errors = 0;
  bit no_idle = 1'b0;

  // decoder state mirror
  phase_e      dec_phase = PH_TOKEN;
  logic [3:0]  dec_nibble = '0;
  int unsigned dec_lits = 0, dec_offset = 0, dec_match = 0, dec_total = 0;
  bit          dec_last_copy = 1'b0;
  int unsigned dec_capacity = CapReset;
  logic [7:0]  dec_history [HistDepth];

  function automatic int unsigned len_sat(int unsigned a, int unsigned b);
    return (a + b > LenMax) ? LenMax : a + b;
  endfunction

  task automatic restart_block();
    dec_phase = PH_TOKEN;
    dec_nibble = '0;
    dec_lits = 0;
    dec_offset = 0;
    dec_match = 0;
    dec_total = 0;
    dec_last_copy = 1'b0;
  endtask

  task automatic emit_result(logic has, logic [7:0] b);
    out_item_t r;
    r.has_byte = has;
    r.out_byte = b;
    r.status = STS_WORKING;
    r.copy_pending = (dec_phase == PH_COPY && dec_match != 0);
    r.produced_count = dec_total[23:0];
    r.run_end = 1'b0;
    burst_results.push_back(r);
  endtask

  task automatic close_item(status_e st);
    int k;
    if (burst_results.size() == 0) emit_result(1'b0, 8'h00);
    k = burst_results.size() - 1;
    burst_results[k].status = st;
    burst_results[k].run_end = 1'b1;
    if (st >= STS_DONE && st <= STS_TOO_FAR) begin
      burst_results[k].copy_pending = 1'b0;
      restart_block();
    end
    foreach (burst_results[i]) expected_results.push_back(burst_results[i]);
    burst_results.delete();
  endtask

  task automatic copy_burst();
    logic [7:0] b;
    while (dec_match != 0 && burst_results.size() < Burst) begin
      b = dec_history[(dec_total - dec_offset) % HistDepth];
      dec_history[dec_total % HistDepth] = b;
      dec_total++;
      dec_match--;
      emit_result(1'b1, b);
    end
    if (dec_match == 0) dec_phase = PH_TOKEN;
  endtask

  task automatic begin_match(bit last, output status_e st);
    if (dec_offset > dec_total) st = STS_TOO_FAR;
    else if (dec_total + dec_match > dec_capacity) st = STS_CAPACITY;
    else begin
      dec_phase = PH_COPY;
      dec_last_copy = last;
      copy_burst();
      st = (dec_phase != PH_COPY && last) ? STS_DONE : STS_WORKING;
    end
  endtask

  function automatic status_e literals_ready(bit last);
    if (dec_total + dec_lits > dec_capacity) return STS_CAPACITY;
    if (last) return STS_TRUNC;
    dec_phase = PH_LITERALS;
    return STS_WORKING;
  endfunction

  // works out the results of one accepted item
  task automatic predict_decode(in_item_t it);
    status_e st;
    logic [7:0] b;
    st = STS_WORKING;
    b = it.in_byte;
    if (it.action == ACT_DRAIN) begin
      if (dec_phase == PH_COPY) begin
        copy_burst();
        if (dec_phase != PH_COPY && dec_last_copy) st = STS_DONE;
      end
    end else begin
      case (dec_phase)
        PH_COPY: begin
          emit_result(1'b0, 8'h00);
          st = STS_BUSY;
        end
        PH_TOKEN: begin
          if (dec_total == 0 && dec_capacity == 0) st = STS_CAPACITY;
          else begin
            dec_nibble = b[3:0];
            dec_lits = b[7:4];
            if (dec_lits == NibMax) begin
              if (it.in_last) st = STS_TRUNC;
              else dec_phase = PH_LIT_EXT;
            end else if (dec_lits != 0) st = literals_ready(it.in_last);
            else if (it.in_last) st = STS_DONE;
            else dec_phase = PH_OFF_LO;
          end
        end
        PH_LIT_EXT: begin
          dec_lits = len_sat(dec_lits, b);
          if (b == ExtByte) st = it.in_last ? STS_TRUNC : STS_WORKING;
          else st = literals_ready(it.in_last);
        end
        PH_LITERALS: begin
          dec_history[dec_total % HistDepth] = b;
          dec_total++;
          dec_lits--;
          if (dec_lits == 0) begin
            dec_phase = PH_OFF_LO;
            emit_result(1'b1, b);
            st = it.in_last ? STS_DONE : STS_WORKING;
          end else begin
            emit_result(1'b1, b);
            st = it.in_last ? STS_TRUNC : STS_WORKING;
          end
        end
        PH_OFF_LO: begin
          dec_offset = b;
          if (it.in_last) st = STS_TRUNC;
          else dec_phase = PH_OFF_HI;
        end
        PH_OFF_HI: begin
          dec_offset = dec_offset | (int'(b) << 8);
          if (dec_offset == 0) st = STS_ZERO_OFF;
          else if (dec_nibble == NibMax) begin
            dec_match = NibMax + MinMatch;
            if (it.in_last) st = STS_TRUNC;
            else dec_phase = PH_MATCH_EXT;
          end else begin
            dec_match = dec_nibble + MinMatch;
            begin_match(it.in_last, st);
          end
        end
        PH_MATCH_EXT: begin
          dec_match = len_sat(dec_match, b);
          if (b == ExtByte) st = it.in_last ? STS_TRUNC : STS_WORKING;
          else begin_match(it.in_last, st);
        end
        default: restart_block();
      endcase
    end
    close_item(st);
  endtask

  // input driver: holds a stalled item, else idles at random unless no_idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_decode(in_data_i);
        void'(pending_items.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 31)) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor: random stall, compares each result with the oldest expected one
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item %p", out_data_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_data_o.has_byte !== e.has_byte) begin
            $error("has_byte exp %0d got %0d", e.has_byte, out_data_o.has_byte);
            errors++;
          end
          if (out_data_o.out_byte !== e.out_byte) begin
            $error("out_byte exp %0h got %0h", e.out_byte, out_data_o.out_byte);
            errors++;
          end
          if (out_data_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data_o.status);
            errors++;
          end
          if (out_data_o.copy_pending !== e.copy_pending) begin
            $error("copy_pending exp %0d got %0d", e.copy_pending, out_data_o.copy_pending);
            errors++;
          end
          if (out_data_o.produced_count !== e.produced_count) begin
            $error("produced_count exp %0d got %0d", e.produced_count,
                   out_data_o.produced_count);
            errors++;
          end
          if (out_data_o.run_end !== e.run_end) begin
            $error("run_end exp %0d got %0d", e.run_end, out_data_o.run_end);
            errors++;
          end
        end
      end
      out_stall_i <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 31);
    end
  end

  task automatic queue_item(logic act, logic [7:0] b, logic last);
    in_item_t it;
    it.action = act;
    it.in_byte = b;
    it.in_last = last;
    pending_items.push_back(it);
  endtask

  // length extension bytes for a remainder past the nibble
  task automatic queue_ext(int unsigned rem);
    while (rem >= 255) begin
      queue_item(ACT_DATA, ExtByte, 1'b0);
      rem -= 255;
    end
    queue_item(ACT_DATA, rem[7:0], 1'b0);
  endtask

  // a well-formed block with random content, drains after long copies and at random
  task automatic queue_block(int nseq);
    int unsigned total, nlit, mlen, off, rem;
    logic [3:0] mnib;
    bit last_seq;
    total = 0;
    for (int s = 0; s < nseq; s++) begin
      last_seq = (s == nseq - 1);
      nlit = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      if (total == 0 && nlit == 0) nlit = 1;
      mnib = ($urandom_range(0, 5) == 0) ? NibMax : 4'($urandom_range(0, 14));
      queue_item(ACT_DATA, {(nlit >= 15) ? NibMax : 4'(nlit), mnib},
                 last_seq && nlit == 0);
      if (nlit >= 15) queue_ext(nlit - 15);
      for (int i = 0; i < nlit; i++)
        queue_item(ACT_DATA, 8'($urandom()), last_seq && i == nlit - 1);
      total += nlit;
      if (last_seq) break;
      off = $urandom_range(1, total);
      queue_item(ACT_DATA, off[7:0], 1'b0);
      mlen = mnib + MinMatch;
      if (mnib == NibMax) begin
        rem = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 20);
        mlen += rem;
        queue_item(ACT_DATA, off[15:8], 1'b0);
        queue_ext(rem);
      end else begin
        queue_item(ACT_DATA, off[15:8], 1'b0);
      end
      total += mlen;
      if (mlen > Burst) begin
        if ($urandom_range(0, 1)) queue_item(ACT_DATA, 8'($urandom()), 1'($urandom()));
        for (int d = 0; d < (mlen - 1) / Burst; d++) queue_item(ACT_DRAIN, 8'($urandom()), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) queue_item(ACT_DRAIN, 8'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [23:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dec_capacity = v;
  endtask

  initial begin
    foreach (dec_history[i]) dec_history[i] = 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: overlapping copy, long match with drains, refusal, errors
    queue_item(ACT_DRAIN, 8'h00, 1'b0);              // idle drain
    queue_item(ACT_DATA, 8'h23, 1'b0);
    queue_item(ACT_DATA, 8'hAA, 1'b0);
    queue_item(ACT_DATA, 8'h55, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);               // offset 1, repeat
    queue_item(ACT_DATA, 8'h0F, 1'b0);
    queue_item(ACT_DATA, 8'h02, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, ExtByte, 1'b0);
    queue_item(ACT_DATA, 8'h64, 1'b1);               // 374 bytes, ends block
    queue_item(ACT_DATA, 8'h77, 1'b0);               // refused busy
    repeat (5) queue_item(ACT_DRAIN, 8'hFF, 1'b1);
    queue_item(ACT_DATA, 8'h10, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);               // zero offset
    queue_item(ACT_DATA, 8'h10, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);
    queue_item(ACT_DATA, 8'hFF, 1'b0);               // offset too far
    queue_item(ACT_DATA, 8'hF0, 1'b1);               // truncated token
    queue_item(ACT_DATA, 8'h20, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b1);               // truncated literals
    queue_item(ACT_DATA, 8'h00, 1'b1);               // empty done
    wait_drained();

    // zero capacity, then small capacity overflow
    write_capacity(24'd0);
    queue_item(ACT_DATA, 8'h11, 1'b0);
    wait_drained();
    write_capacity(24'd3);
    queue_item(ACT_DATA, 8'h40, 1'b0);
    queue_item(ACT_DATA, 8'h20, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b0);
    queue_item(ACT_DATA, 8'h02, 1'b0);
    queue_item(ACT_DATA, 8'h01, 1'b0);
    queue_item(ACT_DATA, 8'h00, 1'b0);               // match overflows
    wait_drained();

    // random phases at several capacities; one without idling
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_capacity(CapReset);
        1: write_capacity(24'($urandom_range(20, 120)));
        2: write_capacity(LenMax);
        default: write_capacity(24'($urandom_range(200, 2000)));
      endcase
      no_idle = (p == 2);
      for (int b = 0; b < 3; b++) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat (4) queue_item(1'($urandom()), 8'($urandom()), 1'($urandom()));
        end
        queue_block($urandom_range(1, 3));
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[lz4_block_decoder] OK");
    end else begin
      $display("[lz4_block_decoder] ERROR");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #20000000;
    $display("[lz4_block_decoder] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
